// File: rtl/longest_prefix_route_lookup_core_assert.svh
// Assertion macros shared by the route lookup modules.
// Each macro places one concurrent assertion that reports through $error.
`ifndef LONGEST_PREFIX_ROUTE_LOOKUP_CORE_ASSERT_SVH
`define LONGEST_PREFIX_ROUTE_LOOKUP_CORE_ASSERT_SVH

// Same-cycle implication.
`define LPRL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LPRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lprl_pkg.sv
// ----------------------------------------------------------------------------
// lprl_pkg
// Shared constants, command and status types and the popcount function of
// the longest-prefix route lookup block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lprl_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ADDR_W      = 32;
  localparam int PORT_W      = 4;
  localparam int LEN_W       = 6;
  localparam int ENTRY_IDX_W = 4;
  localparam int HIDX_W      = 4;

  // Item kinds carried by func
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef struct packed {
    logic             wr_en;     // store or clear one slot from the input item
    logic             start;     // latch lookup address, clear best match
    logic             rd_en;     // read one slot for the scan
    logic [IDX_W-1:0] rd_idx;
    logic             load_out;  // load the result register
    logic             out_zero;  // result is the all-zero write reply
  } lprl_cmd_t;

  typedef struct packed {
    logic out_free;              // result register empty or being taken
  } lprl_status_t;

  // Adder tree: 16 pairs, 8 quads, 4 octets, 2 halves, total.
  function automatic logic [LEN_W-1:0] popcount32(input logic [ADDR_W-1:0] v);
    logic [1:0] p1 [16];
    logic [2:0] p2 [8];
    logic [3:0] p3 [4];
    logic [4:0] p4 [2];
    for (int i = 0; i < 16; i++) begin
      p1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      p2[i] = {1'b0, p1[2*i]} + {1'b0, p1[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      p3[i] = {1'b0, p2[2*i]} + {1'b0, p2[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      p4[i] = {1'b0, p3[2*i]} + {1'b0, p3[2*i+1]};
    end
    return {1'b0, p4[0]} + {1'b0, p4[1]};
  endfunction

endpackage

// File: rtl/lprl_ctrl.sv
// ----------------------------------------------------------------------------
// lprl_ctrl
// Sequencer: takes items, steps the table scan, hands results to the
// datapath's output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "longest_prefix_route_lookup_core_assert.svh"

module lprl_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            func_i,
  input  logic [lprl_pkg::ENTRY_IDX_W-1:0] entry_index_i,
  input  lprl_pkg::lprl_status_t          status_i,
  output lprl_pkg::lprl_cmd_t             cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [lprl_pkg::IDX_W-1:0] LAST_IDX =
    lprl_pkg::IDX_W'(lprl_pkg::TABLE_DEPTH - 1);

  logic [1:0]                  state_q, state_d;
  logic [lprl_pkg::IDX_W-1:0]  cnt_q, cnt_d;
  logic                        is_write_q, is_write_d;
  logic                        accept;
  logic                        in_range;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = (32'(entry_index_i) < 32'(lprl_pkg::TABLE_DEPTH));

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    is_write_d      = is_write_q;
    cmd_o           = '0;
    cmd_o.rd_idx    = cnt_q;
    cmd_o.out_zero  = is_write_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (func_i == lprl_pkg::FUNC_LOOKUP) begin
            cmd_o.start = 1'b1;
            cnt_d       = '0;
            is_write_d  = 1'b0;
            state_d     = ST_SCAN;
          end else begin
            cmd_o.wr_en = in_range;
            is_write_d  = 1'b1;
            state_d     = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (cnt_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      is_write_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      is_write_q <= is_write_d;
    end
  end

  `LPRL_ASSERT_NOW(a_load_only_when_free, clk_i, rst_ni, cmd_o.load_out,
                   status_i.out_free, "result loaded into a busy output register")
  `LPRL_ASSERT_NEXT(a_lookup_starts_scan, clk_i, rst_ni,
                    accept && (func_i == lprl_pkg::FUNC_LOOKUP),
                    (state_q == ST_SCAN) && (cnt_q == '0), "lookup did not start at slot zero")
  `LPRL_ASSERT_NEXT(a_scan_ends_in_drain, clk_i, rst_ni,
                    (state_q == ST_SCAN) && (cnt_q == LAST_IDX),
                    state_q == ST_DRAIN, "scan ran past the last slot")

endmodule

// File: rtl/lprl_datapath.sv
// ----------------------------------------------------------------------------
// lprl_datapath
// Route table storage, match and length compare, best-match tracking and the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "longest_prefix_route_lookup_core_assert.svh"

module lprl_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lprl_pkg::lprl_cmd_t              cmd_i,
  output lprl_pkg::lprl_status_t           status_o,
  input  logic [lprl_pkg::ENTRY_IDX_W-1:0] entry_index_i,
  input  logic                             entry_valid_i,
  input  logic [lprl_pkg::ADDR_W-1:0]      route_prefix_i,
  input  logic [lprl_pkg::ADDR_W-1:0]      route_mask_i,
  input  logic [lprl_pkg::ADDR_W-1:0]      route_gateway_i,
  input  logic [lprl_pkg::PORT_W-1:0]      route_port_i,
  input  logic [lprl_pkg::ADDR_W-1:0]      lookup_addr_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             hit_o,
  output logic [lprl_pkg::ADDR_W-1:0]      next_hop_o,
  output logic [lprl_pkg::PORT_W-1:0]      out_port_o,
  output logic [lprl_pkg::LEN_W-1:0]       prefix_len_o,
  output logic [lprl_pkg::HIDX_W-1:0]      hit_index_o
);

  localparam int DEPTH = lprl_pkg::TABLE_DEPTH;
  localparam int IW    = lprl_pkg::IDX_W;
  localparam int AW    = lprl_pkg::ADDR_W;
  localparam int PW    = lprl_pkg::PORT_W;
  localparam int LW    = lprl_pkg::LEN_W;

  logic [AW-1:0] prefix_mem [DEPTH];
  logic [AW-1:0] mask_mem   [DEPTH];
  logic [AW-1:0] gw_mem     [DEPTH];
  logic [PW-1:0] port_mem   [DEPTH];
  logic [DEPTH-1:0] valid_q;

  logic [IW-1:0] wr_idx;
  logic [AW-1:0] rd_pre_q, rd_mask_q, rd_gw_q;
  logic [PW-1:0] rd_port_q;
  logic          rd_vld_q;
  logic [IW-1:0] rd_idx_q;
  logic          eval_q;

  logic [AW-1:0] addr_q;
  logic          best_found_q;
  logic [LW-1:0] best_len_q;
  logic [AW-1:0] best_gw_q;
  logic [PW-1:0] best_port_q;
  logic [IW-1:0] best_idx_q;

  logic          match;
  logic [LW-1:0] cur_len;
  logic          take;
  logic          out_valid_q;

  assign wr_idx = IW'(entry_index_i);

  // Table: write from the input item, registered read for the scan.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && entry_valid_i) begin
      prefix_mem[wr_idx] <= route_prefix_i;
      mask_mem[wr_idx]   <= route_mask_i;
      gw_mem[wr_idx]     <= route_gateway_i;
      port_mem[wr_idx]   <= route_port_i;
    end
    if (cmd_i.rd_en) begin
      rd_pre_q  <= prefix_mem[cmd_i.rd_idx];
      rd_mask_q <= mask_mem[cmd_i.rd_idx];
      rd_gw_q   <= gw_mem[cmd_i.rd_idx];
      rd_port_q <= port_mem[cmd_i.rd_idx];
      rd_vld_q  <= valid_q[cmd_i.rd_idx];
      rd_idx_q  <= cmd_i.rd_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      eval_q  <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        valid_q[wr_idx] <= entry_valid_i;
      end
      eval_q <= cmd_i.rd_en;
    end
  end

  assign match   = eval_q && rd_vld_q && (((rd_pre_q ^ addr_q) & rd_mask_q) == '0);
  assign cur_len = lprl_pkg::popcount32(rd_mask_q);
  assign take    = match && (!best_found_q || (cur_len > best_len_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      addr_q <= lookup_addr_i;
    end
    if (take) begin
      best_len_q  <= cur_len;
      best_gw_q   <= rd_gw_q;
      best_port_q <= rd_port_q;
      best_idx_q  <= rd_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_found_q <= 1'b0;
    end else if (cmd_i.start) begin
      best_found_q <= 1'b0;
    end else if (take) begin
      best_found_q <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (cmd_i.out_zero || !best_found_q) begin
        hit_o        <= 1'b0;
        next_hop_o   <= '0;
        out_port_o   <= '0;
        prefix_len_o <= '0;
        hit_index_o  <= '0;
      end else begin
        hit_o        <= 1'b1;
        next_hop_o   <= (best_gw_q != '0) ? best_gw_q : addr_q;
        out_port_o   <= best_port_q;
        prefix_len_o <= best_len_q;
        hit_index_o  <= lprl_pkg::HIDX_W'(best_idx_q);
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  `LPRL_ASSERT_NEXT(a_write_reply_misses, clk_i, rst_ni, cmd_i.load_out && cmd_i.out_zero,
                    out_valid_q && !hit_o, "write reply carries a hit")
  `LPRL_ASSERT_NEXT(a_start_clears_best, clk_i, rst_ni, cmd_i.start,
                    !best_found_q, "best match survived a new lookup")
  `LPRL_ASSERT_NOW(a_len_in_range, clk_i, rst_ni, out_valid_q && hit_o,
                   prefix_len_o <= LW'(AW), "prefix length above address width")

endmodule

// File: rtl/longest_prefix_route_lookup_core.sv
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup_core
// IPv4 route table with longest-prefix lookup over sixteen slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per handshake.
//   func_i selects a route write or an address lookup. A write stores or
//   clears the slot given by entry_index_i in the accept cycle; an index
//   outside the table is dropped. A lookup reads one slot per cycle through
//   a registered table port and holds the input through its steps: accept,
//   a read of each slot, one compare and one load.
//   A write goes from accept straight to the result load.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result
//   per item; writes and misses return all-zero fields.
//   The result register decouples the sides: a new item is taken while an
//   old result still waits. When the receiver stalls, the result holds and
//   a finished lookup waits in its last step until the register frees up.
//   Reset clears all slot valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module longest_prefix_route_lookup_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             func_i,
  input  logic [lprl_pkg::ENTRY_IDX_W-1:0] entry_index_i,
  input  logic                             entry_valid_i,
  input  logic [lprl_pkg::ADDR_W-1:0]      route_prefix_i,
  input  logic [lprl_pkg::ADDR_W-1:0]      route_mask_i,
  input  logic [lprl_pkg::ADDR_W-1:0]      route_gateway_i,
  input  logic [lprl_pkg::PORT_W-1:0]      route_port_i,
  input  logic [lprl_pkg::ADDR_W-1:0]      lookup_addr_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             hit_o,
  output logic [lprl_pkg::ADDR_W-1:0]      next_hop_o,
  output logic [lprl_pkg::PORT_W-1:0]      out_port_o,
  output logic [lprl_pkg::LEN_W-1:0]       prefix_len_o,
  output logic [lprl_pkg::HIDX_W-1:0]      hit_index_o
);

  // Commands flow from the sequencer to the datapath; only the
  // result-register status flows back.
  lprl_pkg::lprl_cmd_t    cmd;
  lprl_pkg::lprl_status_t status;

  lprl_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .entry_index_i (entry_index_i),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  lprl_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .entry_index_i   (entry_index_i),
    .entry_valid_i   (entry_valid_i),
    .route_prefix_i  (route_prefix_i),
    .route_mask_i    (route_mask_i),
    .route_gateway_i (route_gateway_i),
    .route_port_i    (route_port_i),
    .lookup_addr_i   (lookup_addr_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hit_o           (hit_o),
    .next_hop_o      (next_hop_o),
    .out_port_o      (out_port_o),
    .prefix_len_o    (prefix_len_o),
    .hit_index_o     (hit_index_o)
  );

endmodule
